/* src/cbcb_pkg.sv */
// ----------------------------------------------------------------------------
// cbcb_pkg
// Shared types and constants of the circle/box collision and bounce block.
// ----------------------------------------------------------------------------
package cbcb_pkg;

  localparam int BOX_DIM_BITS   = 12;
  localparam int MIN_SPEED_BITS = 15;
  localparam int RADIUS_BITS    = 10;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 15;

  // largest per-axis distance for which the squared-distance test is made
  localparam int NEAR_LIMIT = 1023;

  // register reset values
  localparam logic [BOX_DIM_BITS-1:0]   BOX_WIDTH_RST  = 12'd1280;
  localparam logic [BOX_DIM_BITS-1:0]   BOX_HEIGHT_RST = 12'd320;
  localparam logic [MIN_SPEED_BITS-1:0] MIN_VSPEED_RST = 15'd800;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_BOX_WIDTH  = 2'd0,
    CFG_BOX_HEIGHT = 2'd1,
    CFG_MIN_VSPEED = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [BOX_DIM_BITS-1:0]   box_width;
    logic [BOX_DIM_BITS-1:0]   box_height;
    logic [MIN_SPEED_BITS-1:0] min_vertical_speed;
  } cfg_regs_t;

endpackage

/* src/cbcb_in_if.sv */
// ----------------------------------------------------------------------------
// cbcb_in_if
// Input channel: one ball and one box per transfer.
// ----------------------------------------------------------------------------
interface cbcb_in_if #(
  parameter int COORD_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic signed [COORD_BITS-1:0]        ball_x;
  logic signed [COORD_BITS-1:0]        ball_y;
  logic [cbcb_pkg::RADIUS_BITS-1:0]    ball_radius;
  logic signed [COORD_BITS-1:0]        ball_vx;
  logic signed [COORD_BITS-1:0]        ball_vy;
  logic signed [COORD_BITS-1:0]        box_x;
  logic signed [COORD_BITS-1:0]        box_y;
  logic                                box_active;

  modport source (
    output valid, ball_x, ball_y, ball_radius, ball_vx, ball_vy, box_x, box_y, box_active,
    input  ready
  );
  modport sink (
    input  valid, ball_x, ball_y, ball_radius, ball_vx, ball_vy, box_x, box_y, box_active,
    output ready
  );
endinterface

/* src/cbcb_out_if.sv */
// ----------------------------------------------------------------------------
// cbcb_out_if
// Output channel: hit flag and the ball after bounce, one per transfer.
// ----------------------------------------------------------------------------
interface cbcb_out_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [COORD_BITS-1:0] new_x;
  logic signed [COORD_BITS-1:0] new_y;
  logic signed [COORD_BITS-1:0] new_vx;
  logic signed [COORD_BITS-1:0] new_vy;

  modport source (
    output valid, hit, new_x, new_y, new_vx, new_vy,
    input  ready
  );
  modport sink (
    input  valid, hit, new_x, new_y, new_vx, new_vy,
    output ready
  );
endinterface

/* src/cbcb_front.sv */
// ----------------------------------------------------------------------------
// cbcb_front
// Two-stage front end: clamp and distance test, overlap choice, push-out,
// velocity flip and the squared speed terms for the back end.
// ----------------------------------------------------------------------------
module cbcb_front #(
  parameter  int COORD_BITS = 16,
  localparam int C  = COORD_BITS,
  localparam int MW = (C > 15) ? C : 15,
  localparam int VW = MW + 1,
  localparam int PW = C + 2,
  localparam int DW = C + 3,
  localparam int OW = C + 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cbcb_pkg::cfg_regs_t     cfg,
  cbcb_in_if.sink                 in_ch,
  output logic                    item_valid,
  input  logic                    item_ready,
  output logic                    hit,
  output logic                    vert,
  output logic signed [PW-1:0]    pos_x,
  output logic signed [PW-1:0]    pos_y,
  output logic signed [VW-1:0]    vel_x,
  output logic signed [VW-1:0]    vel_y,
  output logic [2*MW-1:0]         sq_x,
  output logic [2*MW-1:0]         sq_y,
  output logic [2*MW-1:0]         sq_ny
);
  import cbcb_pkg::*;

  localparam int R = RADIUS_BITS;

  logic adv;

  // stage 1 combinational
  logic signed [DW-1:0] bx, by, qx, qy, w, h, qxw, qyh, cx0, cy0, cx, cy, dx, dy, adx, ady;
  logic signed [DW-1:0] d2x, d2y;

  // stage 1 registers
  logic                 s1v;
  logic                 s1_active;
  logic [R-1:0]         s1_r;
  logic signed [C-1:0]  s1_bx, s1_by, s1_vx, s1_vy, s1_qx, s1_qy;
  logic [R-1:0]         s1_adx, s1_ady;
  logic                 s1_okx, s1_oky;
  logic signed [DW-1:0] s1_d2x, s1_d2y;

  // stage 2 combinational
  logic [2*R-1:0]       sqdx, sqdy, rr;
  logic [2*R:0]         near2;
  logic                 hit_c, horiz;
  logic signed [OW-1:0] d2xo, d2yo, ad2x, ad2y, ox, oy;
  logic signed [PW-1:0] qxp, qyp, wp, hp, rp, push_x, push_y;
  logic signed [VW-1:0] vxv, vyv, nvx, nvy, mvs_v, vy_b;
  logic [MW-1:0]        avx, avy, mvs_m;
  logic                 keep;

  assign adv         = !item_valid || item_ready;
  assign in_ch.ready = adv;

  // clamp the centre to the box and take the distance to it
  assign bx  = DW'(in_ch.ball_x);
  assign by  = DW'(in_ch.ball_y);
  assign qx  = DW'(in_ch.box_x);
  assign qy  = DW'(in_ch.box_y);
  assign w   = DW'({1'b0, cfg.box_width});
  assign h   = DW'({1'b0, cfg.box_height});
  assign qxw = qx + w;
  assign qyh = qy + h;
  assign cx0 = (bx < qxw) ? bx : qxw;
  assign cy0 = (by < qyh) ? by : qyh;
  assign cx  = (cx0 < qx) ? qx : cx0;
  assign cy  = (cy0 < qy) ? qy : cy0;
  assign dx  = bx - cx;
  assign dy  = by - cy;
  assign adx = (dx < 0) ? -dx : dx;
  assign ady = (dy < 0) ? -dy : dy;
  // centre offsets from the box centre, doubled
  assign d2x = (bx <<< 1) - (qx <<< 1) - w;
  assign d2y = (by <<< 1) - (qy <<< 1) - h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
    end else if (adv) begin
      s1v <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ch.valid) begin
      s1_active <= in_ch.box_active;
      s1_r      <= in_ch.ball_radius;
      s1_bx     <= in_ch.ball_x;
      s1_by     <= in_ch.ball_y;
      s1_vx     <= in_ch.ball_vx;
      s1_vy     <= in_ch.ball_vy;
      s1_qx     <= in_ch.box_x;
      s1_qy     <= in_ch.box_y;
      s1_adx    <= adx[R-1:0];
      s1_ady    <= ady[R-1:0];
      s1_okx    <= (adx <= DW'(NEAR_LIMIT));
      s1_oky    <= (ady <= DW'(NEAR_LIMIT));
      s1_d2x    <= d2x;
      s1_d2y    <= d2y;
    end
  end

  // hit test
  assign sqdx  = (2*R)'(s1_adx) * (2*R)'(s1_adx);
  assign sqdy  = (2*R)'(s1_ady) * (2*R)'(s1_ady);
  assign rr    = (2*R)'(s1_r) * (2*R)'(s1_r);
  assign near2 = (2*R+1)'(sqdx) + (2*R+1)'(sqdy);
  assign hit_c = s1_active && s1_okx && s1_oky && (near2 < (2*R+1)'(rr));

  // overlap per axis at doubled scale; tie goes vertical
  assign d2xo  = OW'(s1_d2x);
  assign d2yo  = OW'(s1_d2y);
  assign ad2x  = (d2xo < 0) ? -d2xo : d2xo;
  assign ad2y  = (d2yo < 0) ? -d2yo : d2yo;
  assign ox    = OW'({1'b0, cfg.box_width}) + OW'({1'b0, s1_r, 1'b0}) - ad2x;
  assign oy    = OW'({1'b0, cfg.box_height}) + OW'({1'b0, s1_r, 1'b0}) - ad2y;
  assign horiz = ox < oy;

  // push-out targets
  assign qxp    = PW'(s1_qx);
  assign qyp    = PW'(s1_qy);
  assign wp     = PW'({1'b0, cfg.box_width});
  assign hp     = PW'({1'b0, cfg.box_height});
  assign rp     = PW'({1'b0, s1_r});
  assign push_x = (s1_d2x > 0) ? qxp + wp + rp : qxp - rp;
  assign push_y = (s1_d2y > 0) ? qyp + hp + rp : qyp - rp;

  // velocity flip and the vertical speed floor
  assign vxv   = VW'(s1_vx);
  assign vyv   = VW'(s1_vy);
  assign nvx   = -vxv;
  assign nvy   = -vyv;
  assign avx   = (vxv < 0) ? nvx[MW-1:0] : vxv[MW-1:0];
  assign avy   = (vyv < 0) ? nvy[MW-1:0] : vyv[MW-1:0];
  assign mvs_m = MW'(cfg.min_vertical_speed);
  assign mvs_v = VW'({1'b0, cfg.min_vertical_speed});
  assign keep  = avy >= mvs_m;
  assign vy_b  = keep ? nvy : ((nvy > 0) ? mvs_v : -mvs_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (adv) begin
      item_valid <= s1v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1v) begin
      hit   <= hit_c;
      vert  <= hit_c && !horiz;
      pos_x <= (hit_c && horiz) ? push_x : PW'(s1_bx);
      pos_y <= (hit_c && !horiz) ? push_y : PW'(s1_by);
      vel_x <= (hit_c && horiz) ? nvx : vxv;
      vel_y <= (hit_c && !horiz) ? vy_b : vyv;
      sq_x  <= (2*MW)'(avx) * (2*MW)'(avx);
      sq_y  <= (2*MW)'(avy) * (2*MW)'(avy);
      sq_ny <= keep ? (2*MW)'(avy) * (2*MW)'(avy) : (2*MW)'(mvs_m) * (2*MW)'(mvs_m);
    end
  end

  // an inactive box never yields a hit
  a_inactive_no_hit: assert property (@(posedge clk) disable iff (rst)
    (adv && s1v && !s1_active) |=> !hit)
    else $error("hit on inactive box");

endmodule

/* src/cbcb_fifo.sv */
// ----------------------------------------------------------------------------
// cbcb_fifo
// Short queue between front and back ends.
// ----------------------------------------------------------------------------
module cbcb_fifo #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [AW:0]      count;

  assign full  = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_level: assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(DEPTH))
    else $error("queue level overflow");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

/* src/cbcb_back.sv */
// ----------------------------------------------------------------------------
// cbcb_back
// Back end: speed squares, two pipelined square roots (one result bit per
// stage), the rescale product, two pipelined dividers (one quotient bit per
// stage) and the saturating output register.
// ----------------------------------------------------------------------------
module cbcb_back #(
  parameter  int COORD_BITS = 16,
  localparam int C  = COORD_BITS,
  localparam int MW = (C > 15) ? C : 15,
  localparam int VW = MW + 1,
  localparam int PW = C + 2,
  localparam int SW = MW + 1,
  localparam int RW = 2 * SW,
  localparam int NW = MW + SW,
  localparam int XW = MW + 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_pop,
  input  logic                 hit,
  input  logic                 vert,
  input  logic signed [PW-1:0] pos_x,
  input  logic signed [PW-1:0] pos_y,
  input  logic signed [VW-1:0] vel_x,
  input  logic signed [VW-1:0] vel_y,
  input  logic [2*MW-1:0]      sq_x,
  input  logic [2*MW-1:0]      sq_y,
  input  logic [2*MW-1:0]      sq_ny,
  cbcb_out_if.source           out_ch
);
  import cbcb_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [VW-1:0] vel_x;
    logic signed [VW-1:0] vel_y;
    logic                 rescale;
    logic                 neg_x;
    logic                 neg_y;
    logic [SW-1:0]        den;
  } pl_t;

  typedef struct packed {
    logic [SW:0]   rem;
    logic [SW-1:0] root;
    logic [RW-1:0] rad;
  } sq_t;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [SW-1:0] lo;
    logic [SW-1:0] q;
  } dv_t;

  // one bit of a restoring square root
  function automatic sq_t sq_step(input sq_t s);
    logic [SW+2:0] t;
    logic [SW+2:0] trial;
    sq_t           r;
    t     = {s.rem, s.rad[RW-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = s.rad << 2;
    if (t >= trial) begin
      t      = t - trial;
      r.root = {s.root[SW-2:0], 1'b1};
    end else begin
      r.root = {s.root[SW-2:0], 1'b0};
    end
    r.rem = t[SW:0];
    return r;
  endfunction

  // one bit of a restoring divide
  function automatic dv_t dv_step(input dv_t s, input logic [SW-1:0] den);
    logic [SW:0] t;
    logic        ge;
    dv_t         r;
    t  = {s.rem, s.lo[SW-1]};
    ge = t >= {1'b0, den};
    if (ge) begin
      t = t - {1'b0, den};
    end
    r.rem = t[SW-1:0];
    r.lo  = s.lo << 1;
    r.q   = {s.q[SW-2:0], ge};
    return r;
  endfunction

  function automatic logic [MW-1:0] mag_v(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] n;
    n = -v;
    return (v < 0) ? n[MW-1:0] : v[MW-1:0];
  endfunction

  function automatic logic signed [C-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = XW'({1'b0, {(C-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) begin
      return hi[C-1:0];
    end else if (v < lo) begin
      return lo[C-1:0];
    end
    return v[C-1:0];
  endfunction

  logic adv;

  logic          sv  [0:SW];
  pl_t           psq [0:SW];
  sq_t           so  [0:SW];
  sq_t           sn  [0:SW];

  logic          dvv [0:SW];
  pl_t           pdv [0:SW];
  dv_t           dx  [0:SW];
  dv_t           dy  [0:SW];

  logic [2*MW:0] old_sq, sum_ny, new_sq;
  logic [MW-1:0] ax, ay;
  logic [SW-1:0] old_sp, new_sp;
  logic [NW-1:0] num_x, num_y;
  pl_t           pm, pf;
  logic signed [XW-1:0] qxs, qys, fvx, fvy;

  assign adv      = !out_ch.valid || out_ch.ready;
  assign item_pop = adv && item_valid;

  // speed squares before and after the bounce
  assign old_sq = (2*MW+1)'(sq_x) + (2*MW+1)'(sq_y);
  assign sum_ny = (2*MW+1)'(sq_x) + (2*MW+1)'(sq_ny);
  assign new_sq = vert ? sum_ny : old_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      psq[0].hit     <= hit;
      psq[0].pos_x   <= pos_x;
      psq[0].pos_y   <= pos_y;
      psq[0].vel_x   <= vel_x;
      psq[0].vel_y   <= vel_y;
      psq[0].rescale <= 1'b0;
      psq[0].neg_x   <= 1'b0;
      psq[0].neg_y   <= 1'b0;
      psq[0].den     <= '0;
      so[0]          <= '{rem: '0, root: '0, rad: RW'(old_sq)};
      sn[0]          <= '{rem: '0, root: '0, rad: RW'(new_sq)};
    end
  end

  // square root stages
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        psq[k+1] <= psq[k];
        so[k+1]  <= sq_step(so[k]);
        sn[k+1]  <= sq_step(sn[k]);
      end
    end
  end

  // rescale numerators
  assign old_sp = so[SW].root;
  assign new_sp = sn[SW].root;
  assign ax     = mag_v(psq[SW].vel_x);
  assign ay     = mag_v(psq[SW].vel_y);
  assign num_x  = NW'(ax) * NW'(old_sp);
  assign num_y  = NW'(ay) * NW'(old_sp);

  always_comb begin
    pm         = psq[SW];
    pm.rescale = psq[SW].hit && (old_sp != '0) && (new_sp != '0);
    pm.neg_x   = psq[SW].vel_x < 0;
    pm.neg_y   = psq[SW].vel_y < 0;
    pm.den     = new_sp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= sv[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pdv[0] <= pm;
      dx[0]  <= '{rem: SW'(num_x[NW-1:SW]), lo: num_x[SW-1:0], q: '0};
      dy[0]  <= '{rem: SW'(num_y[NW-1:SW]), lo: num_y[SW-1:0], q: '0};
    end
  end

  // divide stages
  for (genvar k = 0; k < SW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (adv) begin
        dvv[k+1] <= dvv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        pdv[k+1] <= pdv[k];
        dx[k+1]  <= dv_step(dx[k], pdv[k].den);
        dy[k+1]  <= dv_step(dy[k], pdv[k].den);
      end
    end
  end

  // sign restore and saturation
  assign pf  = pdv[SW];
  assign qxs = XW'({1'b0, dx[SW].q});
  assign qys = XW'({1'b0, dy[SW].q});
  assign fvx = pf.rescale ? (pf.neg_x ? -qxs : qxs) : XW'(pf.vel_x);
  assign fvy = pf.rescale ? (pf.neg_y ? -qys : qys) : XW'(pf.vel_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= dvv[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.hit    <= pf.hit;
      out_ch.new_x  <= sat(XW'(pf.pos_x));
      out_ch.new_y  <= sat(XW'(pf.pos_y));
      out_ch.new_vx <= sat(fvx);
      out_ch.new_vy <= sat(fvy);
    end
  end

  // no rescale without a hit
  a_rescale_hit: assert property (@(posedge clk) disable iff (rst)
    (dvv[0] && pdv[0].rescale) |-> pdv[0].hit)
    else $error("rescale without hit");

endmodule

/* src/circle_box_collision_bounce.sv */
// ----------------------------------------------------------------------------
// circle_box_collision_bounce
// Ball against axis-aligned box test with push-out, bounce and speed rescale.
// ----------------------------------------------------------------------------
// Takes one ball/box pair per clock unless the pipeline stalls and gives one
// result per pair, in order. The back end holds the two bit-per-stage square
// roots and the bit-per-stage dividers; a four-entry queue between the
// two-stage front end and the back end lets each side stall on its own.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no item is in flight.
module circle_box_collision_bounce #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  cbcb_in_if.sink                             in_ch,
  cbcb_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [cbcb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cbcb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import cbcb_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int MW = (C > 15) ? C : 15;
  localparam int VW = MW + 1;
  localparam int PW = C + 2;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic                 hit;
    logic                 vert;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [VW-1:0] vel_x;
    logic signed [VW-1:0] vel_y;
    logic [2*MW-1:0]      sq_x;
    logic [2*MW-1:0]      sq_y;
    logic [2*MW-1:0]      sq_ny;
  } mid_t;

  cfg_regs_t cfg;
  mid_t      fw, qr;
  logic      f_valid, q_full, q_empty, q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_width          <= BOX_WIDTH_RST;
      cfg.box_height         <= BOX_HEIGHT_RST;
      cfg.min_vertical_speed <= MIN_VSPEED_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_BOX_WIDTH:  cfg.box_width          <= cfg_data[BOX_DIM_BITS-1:0];
        CFG_BOX_HEIGHT: cfg.box_height         <= cfg_data[BOX_DIM_BITS-1:0];
        CFG_MIN_VSPEED: cfg.min_vertical_speed <= cfg_data[MIN_SPEED_BITS-1:0];
        default: ;
      endcase
    end
  end

  cbcb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .item_valid (f_valid),
    .item_ready (!q_full),
    .hit        (fw.hit),
    .vert       (fw.vert),
    .pos_x      (fw.pos_x),
    .pos_y      (fw.pos_y),
    .vel_x      (fw.vel_x),
    .vel_y      (fw.vel_y),
    .sq_x       (fw.sq_x),
    .sq_y       (fw.sq_y),
    .sq_ny      (fw.sq_ny)
  );

  cbcb_fifo #(.WIDTH($bits(mid_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid && !q_full),
    .wdata (fw),
    .pop   (q_pop),
    .rdata (qr),
    .full  (q_full),
    .empty (q_empty)
  );

  cbcb_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!q_empty),
    .item_pop   (q_pop),
    .hit        (qr.hit),
    .vert       (qr.vert),
    .pos_x      (qr.pos_x),
    .pos_y      (qr.pos_y),
    .vel_x      (qr.vel_x),
    .vel_y      (qr.vel_y),
    .sq_x       (qr.sq_x),
    .sq_y       (qr.sq_y),
    .sq_ny      (qr.sq_ny),
    .out_ch     (out_ch)
  );

endmodule
